// ===== hw/rtl/bdq_pkg.sv =====
// Shared types and constants for the bounded double-ended queue.
// Holds opcode and status codes, field widths and the controller command.
// No dependencies.
package bdq_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned WidthDefault = 32;

  localparam int unsigned OpW     = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 5;

  typedef enum logic [OpW-1:0] {
    OpPushBack  = 3'd0,
    OpPopFront  = 3'd1,
    OpPopBack   = 3'd2,
    OpPeekFront = 3'd3,
    OpPeekBack  = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage

// ===== hw/rtl/bdq_ram.sv =====
// Generic single-port RAM with registered read data.
// Parameters set the word width and the depth. No dependencies.
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bdq_ctrl.sv =====
// Handshake controller for the bounded double-ended queue.
// Depends on bdq_pkg for the command struct.
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic {
    StIdle,
    StResp
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q     <= StResp;
            in_ready_q  <= 1'b0;
            out_valid_q <= 1'b1;
          end
        end
        StResp: begin
          if (out_ready_i) begin
            state_q     <= StIdle;
            in_ready_q  <= 1'b1;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= StIdle;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;
  assign cmd_o.exec  = in_valid_i & in_ready_q;

endmodule

// ===== hw/rtl/bdq_dpath.sv =====
// Datapath of the bounded double-ended queue: ring pointers, count and result.
// Depends on bdq_pkg and instantiates bdq_ram for the element store.
module bdq_dpath
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  parameter int unsigned WIDTH = WidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic [OpW-1:0]     opcode_i,
  input  logic [DataW-1:0]   data_in_i,
  output logic [DataW-1:0]   data_out_o,
  output logic [StatusW-1:0] status_o,
  output logic [OccW-1:0]    occupancy_o,
  output logic               is_empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW:0]   DepthSum = (PtrW+1)'(DEPTH);
  localparam logic [PtrW-1:0] LastPos  = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(DEPTH);

  logic [PtrW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;
  status_e         status_q, status_d;
  logic            rd_sel_q, rd_sel_d;

  logic [PtrW-1:0] offset;
  logic [PtrW:0]   pos_sum;
  logic [PtrW-1:0] addr;
  logic [PtrW-1:0] next_front;
  logic [CntW-1:0] back_off;
  logic            we;
  logic            re;
  logic            is_full;
  logic            none_held;

  logic [WIDTH+DataW-1:0] din_ext;
  logic [WIDTH-1:0]       wdata;
  logic [WIDTH-1:0]       rdata;
  logic [WIDTH+DataW-1:0] dout_ext;
  logic [CntW+OccW-1:0]   occ_ext;

  assign din_ext   = {{WIDTH{1'b0}}, data_in_i};
  assign wdata     = din_ext[WIDTH-1:0];
  assign is_full   = (count_q == FullCnt);
  assign none_held = (count_q == '0);
  assign back_off  = count_q - CntW'(1);

  assign next_front = (front_q == LastPos) ? '0 : front_q + PtrW'(1);
  assign pos_sum    = {1'b0, front_q} + {1'b0, offset};
  always_comb begin
    if (pos_sum >= DepthSum) begin
      addr = PtrW'(pos_sum - DepthSum);
    end else begin
      addr = pos_sum[PtrW-1:0];
    end
  end

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = status_q;
    rd_sel_d = rd_sel_q;
    offset   = '0;
    we       = 1'b0;
    re       = 1'b0;
    if (cmd_i.exec) begin
      status_d = StOk;
      rd_sel_d = 1'b0;
      case (op_e'(opcode_i))
        OpPushBack: begin
          offset = count_q[PtrW-1:0];
          if (is_full) begin
            status_d = StFull;
          end else begin
            we      = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        OpPopFront, OpPeekFront: begin
          if (none_held) begin
            status_d = StEmpty;
          end else begin
            re       = 1'b1;
            rd_sel_d = 1'b1;
            if (op_e'(opcode_i) == OpPopFront) begin
              front_d = next_front;
              count_d = back_off;
            end
          end
        end
        OpPopBack, OpPeekBack: begin
          offset = back_off[PtrW-1:0];
          if (none_held) begin
            status_d = StEmpty;
          end else begin
            re       = 1'b1;
            rd_sel_d = 1'b1;
            if (op_e'(opcode_i) == OpPopBack) begin
              count_d = back_off;
            end
          end
        end
        default: begin
          status_d = StOk;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      status_q <= StOk;
      rd_sel_q <= 1'b0;
    end else begin
      front_q  <= front_d;
      count_q  <= count_d;
      status_q <= status_d;
      rd_sel_q <= rd_sel_d;
    end
  end

  bdq_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .re_i   (re),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign dout_ext    = {{DataW{1'b0}}, rdata};
  assign data_out_o  = rd_sel_q ? dout_ext[DataW-1:0] : '0;
  assign status_o    = status_q;
  assign occ_ext     = {{OccW{1'b0}}, count_q};
  assign occupancy_o = occ_ext[OccW-1:0];
  assign is_empty_o  = none_held;

endmodule

// ===== hw/rtl/bounded_deque_core.sv =====
// Top level of the bounded double-ended queue held in a ring store.
// Depends on bdq_pkg; instantiates bdq_ctrl and bdq_dpath.
//
//   Channel | Direction | Handshake             | Payload
//   input   | in        | in_valid_i/in_ready_o | opcode_i, data_in_i
//   output  | out       | out_valid_o/out_ready_i | data_out_o, status_o,
//           |           |                       | occupancy_o, is_empty_o
//
// Each transaction executes and issues the store access in the accept cycle,
// and the result is shown the next cycle, as the single store port has
// registered read data.
// The next transaction is taken in the cycle after the result is accepted.
// Reset clears the front pointer and the count; the store needs no clearing.
module bounded_deque_core
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  parameter int unsigned WIDTH = WidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpW-1:0]     opcode_i,
  input  logic [DataW-1:0]   data_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DataW-1:0]   data_out_o,
  output logic [StatusW-1:0] status_o,
  output logic [OccW-1:0]    occupancy_o,
  output logic               is_empty_o
);

  cmd_t cmd;

  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  bdq_dpath #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .opcode_i   (opcode_i),
    .data_in_i  (data_in_i),
    .data_out_o (data_out_o),
    .status_o   (status_o),
    .occupancy_o(occupancy_o),
    .is_empty_o (is_empty_o)
  );

endmodule

// ===== tb/bdq_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the bounded double-ended queue: it watches both channels,
// predicts each result and compares it field by field. Depends on bdq_pkg.
module bdq_result_checker
  import bdq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [OpW-1:0]     opcode_i,
  input  logic [DataW-1:0]   data_in_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [DataW-1:0]   data_out_i,
  input  logic [StatusW-1:0] status_i,
  input  logic [OccW-1:0]    occupancy_i,
  input  logic               is_empty_i,
  output int unsigned        error_count_o,
  output int unsigned        pending_o
);

  typedef struct packed {
    logic [DataW-1:0] data;
    status_e          status;
    logic [OccW-1:0]  occupancy;
    logic             is_empty;
  } deque_result_t;

  logic [DataW-1:0] ring_mem [DepthDefault];
  logic [3:0]       head_pos;
  logic [OccW-1:0]  held_count;
  deque_result_t    awaited_results [$];
  int unsigned      error_count;

  assign error_count_o = error_count;

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic deque_result_t apply_deque_op(input logic [OpW-1:0] op,
                                                   input logic [DataW-1:0] value);
    deque_result_t res;
    logic [3:0]    slot;
    res = '{data: '0, status: StOk, occupancy: '0, is_empty: 1'b0};
    case (op)
      OpPushBack: begin
        if (held_count >= OccW'(DepthDefault)) begin
          res.status = StFull;
        end else begin
          slot = head_pos + held_count[3:0];
          ring_mem[slot] = value;
          held_count++;
        end
      end
      OpPopFront, OpPeekFront: begin
        if (held_count == '0) begin
          res.status = StEmpty;
        end else begin
          res.data = ring_mem[head_pos];
          if (op == OpPopFront) begin
            head_pos++;
            held_count--;
          end
        end
      end
      OpPopBack, OpPeekBack: begin
        if (held_count == '0) begin
          res.status = StEmpty;
        end else begin
          slot = head_pos + held_count[3:0] - 4'd1;
          res.data = ring_mem[slot];
          if (op == OpPopBack) begin
            held_count--;
          end
        end
      end
      default: begin
      end
    endcase
    res.occupancy = held_count;
    res.is_empty  = (held_count == '0);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t want;
    if (!rst_ni) begin
      head_pos    = '0;
      held_count  = '0;
      error_count = 0;
      awaited_results.delete();
      pending_o   = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        awaited_results.insert(awaited_results.size(), apply_deque_op(opcode_i, data_in_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, data", data_out_i, '0);
        end else begin
          want = awaited_results.pop_front();
          if (data_out_i !== want.data) begin
            report_mismatch("data_out", data_out_i, want.data);
          end
          if (status_i !== want.status) begin
            report_mismatch("status", DataW'(status_i), DataW'(want.status));
          end
          if (occupancy_i !== want.occupancy) begin
            report_mismatch("occupancy", DataW'(occupancy_i), DataW'(want.occupancy));
          end
          if (is_empty_i !== want.is_empty) begin
            report_mismatch("is_empty", DataW'(is_empty_i), DataW'(want.is_empty));
          end
        end
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// ===== tb/tb_bounded_deque_core.sv =====
`timescale 1ns / 100ps
// Testbench top for bounded_deque_core: drives directed and random deque
// operations with random stalls and gives the verdict. Uses bdq_result_checker.
module tb_bounded_deque_core;
  import bdq_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [OpW-1:0]     opcode_i;
  logic [DataW-1:0]   data_in_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [DataW-1:0]   data_out_o;
  logic [StatusW-1:0] status_o;
  logic [OccW-1:0]    occupancy_o;
  logic               is_empty_o;

  int unsigned error_count;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  bounded_deque_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_out_o  (data_out_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o),
    .is_empty_o  (is_empty_o)
  );

  bdq_result_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .opcode_i      (opcode_i),
    .data_in_i     (data_in_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_out_i    (data_out_o),
    .status_i      (status_o),
    .occupancy_i   (occupancy_o),
    .is_empty_i    (is_empty_o),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_bounded_deque_core NOT OK");
    $finish;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic issue_op(input logic [OpW-1:0] op, input logic [DataW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    data_in_i  <= value;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [OpW-1:0] pick_op(input int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) begin
      return OpW'(int'(OpPeekBack) + $urandom_range(3, 1));
    end
    if ($urandom_range(99) < push_pct) begin
      return OpPushBack;
    end
    case ($urandom_range(3))
      0:       return OpPopFront;
      1:       return OpPopBack;
      2:       return OpPeekFront;
      default: return OpPeekBack;
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned remaining;
    int unsigned burst;
    int unsigned push_pct;
    in_valid_i    = 1'b0;
    opcode_i      = OpPushBack;
    data_in_i     = '0;
    send_idle_pct = 33;
    recv_idle_pct = 71;
    rst_ni        = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty queue, unknown opcode, and removing the only element from the back.
    issue_op(OpPopFront, '1);
    issue_op(OpPopBack, '1);
    issue_op(OpPeekFront, '0);
    issue_op(OpPeekBack, '0);
    issue_op(OpW'(int'(OpPeekBack) + 3), '1);
    issue_op(OpPushBack, 32'hA5A5_5A5A);
    issue_op(OpPopBack, '0);
    // Move the front off position zero so that the fill below wraps around.
    issue_op(OpPushBack, 32'h0F0F_F0F0);
    issue_op(OpPopFront, '0);
    // Fill to capacity across the wrap point, then overflow and read both ends.
    for (int i = 0; i < DepthDefault; i++) begin
      issue_op(OpPushBack, (i == 0) ? '0 : (i == 1) ? '1 : $urandom());
    end
    issue_op(OpPushBack, 32'h1234_5678);
    issue_op(OpPeekFront, '0);
    issue_op(OpPeekBack, '0);
    issue_op(OpPopFront, '0);
    issue_op(OpPopBack, '0);

    for (int phase = 0; phase < 3; phase++) begin
      remaining = 400;
      while (remaining > 0) begin
        case ($urandom_range(2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 45;
        endcase
        burst = $urandom_range(24, 1);
        while (burst > 0 && remaining > 0) begin
          issue_op(pick_op(push_pct), pick_value());
          burst--;
          remaining--;
        end
      end
      drain_results();
      if (phase == 0) begin
        send_idle_pct = 71;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("tb_bounded_deque_core OK");
    end else begin
      $display("tb_bounded_deque_core NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_ram.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bdq_dpath.sv
hw/rtl/bounded_deque_core.sv
tb/bdq_result_checker.sv
tb/tb_bounded_deque_core.sv
